FILE: rtl/troc_pkg.sv
// ----------------------------------------------------------------------------
// Tile rectangle occupancy check package
// Shared constants, codes and types of the occupancy check block.
// ----------------------------------------------------------------------------
package troc_pkg;

    localparam int MAX_ROOM_WIDTH  = 64;
    localparam int MAX_ROOM_HEIGHT = 64;
    localparam int COL_W           = $clog2(MAX_ROOM_WIDTH);
    localparam int ROW_W           = $clog2(MAX_ROOM_HEIGHT);

    localparam int ROOM_W  = 7;
    localparam int TILE_W  = 8;
    localparam int COORD_W = 16;
    localparam int SIZE_W  = 12;
    localparam int EDGE_W  = COORD_W + 1;

    localparam int DIV_W     = 16;
    localparam int DIV_STEPS = DIV_W / 2;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

    localparam logic [1:0] CFG_ROOM_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_ROOM_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_TILE_WIDTH  = 2'd2;
    localparam logic [1:0] CFG_TILE_HEIGHT = 2'd3;

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    localparam logic [1:0] EDGE_LEFT   = 2'd0;
    localparam logic [1:0] EDGE_TOP    = 2'd1;
    localparam logic [1:0] EDGE_RIGHT  = 2'd2;
    localparam logic [1:0] EDGE_BOTTOM = 2'd3;

    typedef struct packed {
        logic              start;
        logic [DIV_W-1:0]  dividend;
        logic [TILE_W-1:0] divisor;
    } troc_div_req_t;

endpackage

FILE: rtl/troc_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write and one read per cycle, read data registered.
// ----------------------------------------------------------------------------
module troc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/troc_divider.sv
// ----------------------------------------------------------------------------
// Iterative unsigned divider
// Restoring division of a 16-bit dividend by an 8-bit divisor, two quotient
// bits per cycle.
// ----------------------------------------------------------------------------
module troc_divider
    import troc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  troc_div_req_t     req,
    output logic              done,
    output logic [DIV_W-1:0]  quotient
);

    logic [DIV_W-1:0]     quot_reg, quot_next;
    logic [TILE_W-1:0]    rem_reg, rem_next;
    logic [TILE_W-1:0]    div_reg, div_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;

    logic [TILE_W:0]      trial1, trial2;
    logic                 bit1, bit2;
    logic [TILE_W-1:0]    rem1;

    always_comb
    begin
        trial1 = {rem_reg, quot_reg[DIV_W-1]};
        bit1   = trial1 >= {1'b0, div_reg};
        rem1   = bit1 ? TILE_W'(trial1 - {1'b0, div_reg}) : trial1[TILE_W-1:0];
        trial2 = {rem1, quot_reg[DIV_W-2]};
        bit2   = trial2 >= {1'b0, div_reg};

        quot_next = quot_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;

        if (req.start)
        begin
            quot_next = req.dividend;
            rem_next  = '0;
            div_next  = req.divisor;
            cnt_next  = DIV_CNT_W'(DIV_STEPS);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            quot_next = {quot_reg[DIV_W-3:0], bit1, bit2};
            rem_next  = bit2 ? TILE_W'(trial2 - {1'b0, div_reg}) : trial2[TILE_W-1:0];
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        div_reg  <= div_next;
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule

FILE: rtl/tile_rect_occupancy_check.sv
// ----------------------------------------------------------------------------
// Tile rectangle occupancy check
// Keeps a walkability bitmap of the room and tests whether a world-space
// rectangle lies inside the room on walkable tiles only.
// ----------------------------------------------------------------------------
// A request word either writes the walkable bit of one cell (no response) or
// queries a rectangle (one response word carrying can_occupy). Requests use
// req_valid/req_ready, responses rsp_valid/rsp_ready. The user must write the
// configuration through cfg_we/cfg_index/cfg_data only while the block is
// idle; the block itself does not enforce it. One request is processed at a
// time and req_ready is low while it runs. A cell write reads the bitmap row
// and then writes it back modified. A query runs four floor divisions one
// after another on one shared divider, then reads one bitmap row per cycle
// over the covered rows. No row is read when the rectangle leaves the room or
// covers no tile, and no division runs while a room or tile size is zero.
// The bitmap is a 64 x 64-bit RAM; per-row valid flags cleared at reset make
// every cell read as not walkable until written, so no clearing pass is run.
// Reset restores the register defaults: 64 x 64 room, 8 x 8 tiles.
// A finished response is held in an output register; a new request is taken
// while it waits, and the next response waits until that one is taken.
// ----------------------------------------------------------------------------
module tile_rect_occupancy_check
    import troc_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [1:0]                cfg_index,
    input  logic [TILE_W-1:0]         cfg_data,
    input  logic                      req_valid,
    output logic                      req_ready,
    input  logic                      action,
    input  logic [5:0]                cell_x,
    input  logic [5:0]                cell_y,
    input  logic                      cell_walkable,
    input  logic signed [COORD_W-1:0] pos_x,
    input  logic signed [COORD_W-1:0] pos_y,
    input  logic [SIZE_W-1:0]         size_x,
    input  logic [SIZE_W-1:0]         size_y,
    output logic                      rsp_valid,
    input  logic                      rsp_ready,
    output logic                      can_occupy
);

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_WR_READ   = 4'd1;
    localparam logic [3:0] S_WR_MOD    = 4'd2;
    localparam logic [3:0] S_DIV_START = 4'd3;
    localparam logic [3:0] S_DIV_WAIT  = 4'd4;
    localparam logic [3:0] S_CHECK     = 4'd5;
    localparam logic [3:0] S_SCAN      = 4'd6;
    localparam logic [3:0] S_DRAIN     = 4'd7;
    localparam logic [3:0] S_DONE      = 4'd8;

    logic [3:0]                state_reg, state_next;
    logic [ROOM_W-1:0]         room_width_reg, room_width_next;
    logic [ROOM_W-1:0]         room_height_reg, room_height_next;
    logic [TILE_W-1:0]         tile_width_reg, tile_width_next;
    logic [TILE_W-1:0]         tile_height_reg, tile_height_next;
    logic                      out_valid_reg, out_valid_next;
    logic                      can_occupy_reg, can_occupy_next;
    logic [MAX_ROOM_HEIGHT-1:0] row_valid_reg, row_valid_next;
    logic                      chk_pend_reg, chk_pend_next;

    logic [5:0]                cell_x_reg;
    logic [5:0]                cell_y_reg;
    logic                      cell_walkable_reg;
    logic [COORD_W-1:0]        pos_x_reg;
    logic [COORD_W-1:0]        pos_y_reg;
    logic [SIZE_W-1:0]         size_x_reg;
    logic [SIZE_W-1:0]         size_y_reg;
    logic [1:0]                edge_idx_reg, edge_idx_next;
    logic [DIV_W-1:0]          quot_reg [4];
    logic [3:0]                neg_reg, neg_next;
    logic                      result_reg, result_next;
    logic                      fail_reg, fail_next;
    logic [MAX_ROOM_WIDTH-1:0] mask_reg, mask_next;
    logic [ROW_W-1:0]          row_reg, row_next;
    logic [ROW_W-1:0]          chk_row_reg, chk_row_next;

    logic                      accept;
    logic                      quot_we;
    logic signed [EDGE_W-1:0]  edge_val;
    logic                      edge_neg;
    logic [EDGE_W-1:0]         edge_mag;
    troc_div_req_t             div_req;
    logic                      div_done;
    logic [DIV_W-1:0]          div_quot;

    logic                      ram_we;
    logic [ROW_W-1:0]          ram_raddr;
    logic [MAX_ROOM_WIDTH-1:0] ram_wdata;
    logic [MAX_ROOM_WIDTH-1:0] ram_rdata;
    logic [MAX_ROOM_WIDTH-1:0] wr_row;
    logic [MAX_ROOM_WIDTH-1:0] chk_row_data;
    logic                      row_ok;

    logic [ROOM_W-1:0]         room_w_eff;
    logic [ROOM_W-1:0]         room_h_eff;
    logic                      bounds_ok;
    logic                      span_empty;
    logic                      cell_in_map;
    logic [MAX_ROOM_WIDTH-1:0] span_mask;

    assign req_ready = (state_reg == S_IDLE);
    assign accept    = req_valid && req_ready;
    assign rsp_valid = out_valid_reg;
    assign can_occupy = can_occupy_reg;

    always_comb
    begin
        case (edge_idx_reg)
            EDGE_LEFT:   edge_val = {pos_x_reg[COORD_W-1], pos_x_reg};
            EDGE_TOP:    edge_val = {pos_y_reg[COORD_W-1], pos_y_reg};
            EDGE_RIGHT:  edge_val = {pos_x_reg[COORD_W-1], pos_x_reg}
                                    + {{(EDGE_W-SIZE_W){1'b0}}, size_x_reg}
                                    - EDGE_W'(1);
            default:     edge_val = {pos_y_reg[COORD_W-1], pos_y_reg}
                                    + {{(EDGE_W-SIZE_W){1'b0}}, size_y_reg}
                                    - EDGE_W'(1);
        endcase
        // Floor division of a negative value is the complement of the
        // quotient of its complement.
        edge_neg = edge_val[EDGE_W-1];
        edge_mag = edge_neg ? ~edge_val : edge_val;

        div_req.start    = (state_reg == S_DIV_START);
        div_req.dividend = edge_mag[DIV_W-1:0];
        div_req.divisor  = edge_idx_reg[0] ? tile_height_reg : tile_width_reg;
    end

    troc_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .done     (div_done),
        .quotient (div_quot)
    );

    troc_ram #(
        .WIDTH (MAX_ROOM_WIDTH),
        .DEPTH (MAX_ROOM_HEIGHT)
    ) u_map_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (cell_y_reg[ROW_W-1:0]),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        room_w_eff = (int'(room_width_reg) > MAX_ROOM_WIDTH)
                     ? ROOM_W'(MAX_ROOM_WIDTH) : room_width_reg;
        room_h_eff = (int'(room_height_reg) > MAX_ROOM_HEIGHT)
                     ? ROOM_W'(MAX_ROOM_HEIGHT) : room_height_reg;

        bounds_ok = !neg_reg[EDGE_LEFT] && !neg_reg[EDGE_TOP]
                    && (neg_reg[EDGE_RIGHT]
                        || (quot_reg[EDGE_RIGHT] < {{(DIV_W-ROOM_W){1'b0}}, room_w_eff}))
                    && (neg_reg[EDGE_BOTTOM]
                        || (quot_reg[EDGE_BOTTOM] < {{(DIV_W-ROOM_W){1'b0}}, room_h_eff}));
        span_empty = neg_reg[EDGE_RIGHT] || neg_reg[EDGE_BOTTOM]
                     || (quot_reg[EDGE_RIGHT] < quot_reg[EDGE_LEFT])
                     || (quot_reg[EDGE_BOTTOM] < quot_reg[EDGE_TOP]);

        for (int i = 0; i < MAX_ROOM_WIDTH; i++)
        begin
            span_mask[i] = (DIV_W'(i) >= quot_reg[EDGE_LEFT])
                           && (DIV_W'(i) <= quot_reg[EDGE_RIGHT]);
        end

        cell_in_map = (int'(cell_x_reg) < MAX_ROOM_WIDTH)
                      && (int'(cell_y_reg) < MAX_ROOM_HEIGHT);

        wr_row = row_valid_reg[cell_y_reg[ROW_W-1:0]] ? ram_rdata : '0;
        wr_row[cell_x_reg[COL_W-1:0]] = cell_walkable_reg;
        ram_wdata = wr_row;

        chk_row_data = row_valid_reg[chk_row_reg] ? ram_rdata : '0;
        row_ok       = ((chk_row_data & mask_reg) == mask_reg);

        ram_raddr = (state_reg == S_WR_READ) ? cell_y_reg[ROW_W-1:0] : row_reg;
        ram_we    = (state_reg == S_WR_MOD) && cell_in_map;
    end

    always_comb
    begin
        state_next       = state_reg;
        room_width_next  = room_width_reg;
        room_height_next = room_height_reg;
        tile_width_next  = tile_width_reg;
        tile_height_next = tile_height_reg;
        out_valid_next   = out_valid_reg;
        can_occupy_next  = can_occupy_reg;
        row_valid_next   = row_valid_reg;
        chk_pend_next    = 1'b0;
        edge_idx_next    = edge_idx_reg;
        neg_next         = neg_reg;
        result_next      = result_reg;
        fail_next        = fail_reg;
        mask_next        = mask_reg;
        row_next         = row_reg;
        chk_row_next     = chk_row_reg;
        quot_we          = 1'b0;

        if (cfg_we)
        begin
            case (cfg_index)
                CFG_ROOM_WIDTH:  room_width_next  = cfg_data[ROOM_W-1:0];
                CFG_ROOM_HEIGHT: room_height_next = cfg_data[ROOM_W-1:0];
                CFG_TILE_WIDTH:  tile_width_next  = cfg_data;
                CFG_TILE_HEIGHT: tile_height_next = cfg_data;
                default:         ;
            endcase
        end

        if (out_valid_reg && rsp_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (chk_pend_reg && !row_ok)
        begin
            fail_next = 1'b1;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    edge_idx_next = EDGE_LEFT;
                    if (action == ACT_WRITE)
                    begin
                        state_next = S_WR_READ;
                    end
                    else if ((tile_width_reg == '0) || (tile_height_reg == '0)
                             || (room_width_reg == '0) || (room_height_reg == '0))
                    begin
                        result_next = 1'b0;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        state_next = S_DIV_START;
                    end
                end
            end
            S_WR_READ:
            begin
                state_next = S_WR_MOD;
            end
            S_WR_MOD:
            begin
                if (cell_in_map)
                begin
                    row_valid_next[cell_y_reg[ROW_W-1:0]] = 1'b1;
                end
                state_next = S_IDLE;
            end
            S_DIV_START:
            begin
                state_next = S_DIV_WAIT;
            end
            S_DIV_WAIT:
            begin
                if (div_done)
                begin
                    quot_we                = 1'b1;
                    neg_next[edge_idx_reg] = edge_neg;
                    if (edge_idx_reg == EDGE_BOTTOM)
                    begin
                        state_next = S_CHECK;
                    end
                    else
                    begin
                        edge_idx_next = edge_idx_reg + 1'b1;
                        state_next    = S_DIV_START;
                    end
                end
            end
            S_CHECK:
            begin
                if (!bounds_ok)
                begin
                    result_next = 1'b0;
                    state_next  = S_DONE;
                end
                else if (span_empty)
                begin
                    result_next = 1'b1;
                    state_next  = S_DONE;
                end
                else
                begin
                    mask_next  = span_mask;
                    row_next   = quot_reg[EDGE_TOP][ROW_W-1:0];
                    fail_next  = 1'b0;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                chk_pend_next = 1'b1;
                chk_row_next  = row_reg;
                if (row_reg == quot_reg[EDGE_BOTTOM][ROW_W-1:0])
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    row_next = row_reg + 1'b1;
                end
            end
            S_DRAIN:
            begin
                result_next = !(fail_reg || !row_ok);
                state_next  = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || rsp_ready)
                begin
                    out_valid_next  = 1'b1;
                    can_occupy_next = result_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            room_width_reg  <= ROOM_W'(64);
            room_height_reg <= ROOM_W'(64);
            tile_width_reg  <= TILE_W'(8);
            tile_height_reg <= TILE_W'(8);
            out_valid_reg   <= 1'b0;
            row_valid_reg   <= '0;
            chk_pend_reg    <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            room_width_reg  <= room_width_next;
            room_height_reg <= room_height_next;
            tile_width_reg  <= tile_width_next;
            tile_height_reg <= tile_height_next;
            out_valid_reg   <= out_valid_next;
            row_valid_reg   <= row_valid_next;
            chk_pend_reg    <= chk_pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cell_x_reg        <= cell_x;
            cell_y_reg        <= cell_y;
            cell_walkable_reg <= cell_walkable;
            pos_x_reg         <= pos_x;
            pos_y_reg         <= pos_y;
            size_x_reg        <= size_x;
            size_y_reg        <= size_y;
        end
        if (quot_we)
        begin
            quot_reg[edge_idx_reg] <= div_quot;
        end
        can_occupy_reg <= can_occupy_next;
        edge_idx_reg   <= edge_idx_next;
        neg_reg        <= neg_next;
        result_reg     <= result_next;
        fail_reg       <= fail_next;
        mask_reg       <= mask_next;
        row_reg        <= row_next;
        chk_row_reg    <= chk_row_next;
    end

endmodule

FILE: sim/tile_rect_occupancy_check_tb.sv
// ----------------------------------------------------------------------------
// Tile rectangle occupancy check testbench
// Drives cell writes and rectangle queries through the request handshake and
// checks every response word against a predictor that keeps its own copy of
// the walkability map and the room and tile registers. The run steps through
// several register settings: reset defaults, extreme and zero sizes, then
// random phases. Each random phase fills a corner of the room and then mixes
// queries aimed at that corner with writes and raw noise. Both handshake sides
// idle at random, and once the receiver holds off long enough to stall the
// block's input.
// ----------------------------------------------------------------------------
module tile_rect_occupancy_check_tb
    import troc_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SETTLE_CYCLES = 160;
    localparam int STALL_LIMIT   = 4000;
    localparam int LONG_HOLD     = 300;
    localparam int FOCUS_TILES   = 6;
    localparam int REPORT_MAX    = 10;

    typedef struct {
        logic                      action;
        logic [COL_W-1:0]          cx;
        logic [ROW_W-1:0]          cy;
        logic                      walk;
        logic signed [COORD_W-1:0] px;
        logic signed [COORD_W-1:0] py;
        logic [SIZE_W-1:0]         sx;
        logic [SIZE_W-1:0]         sy;
    } tile_word_t;

    typedef enum {RX_OPEN, RX_CHOPPY, RX_SLOW} rx_mode_t;

    logic                      clk           = 1'b0;
    logic                      rst_n         = 1'b0;
    logic                      cfg_we        = 1'b0;
    logic [1:0]                cfg_index     = CFG_ROOM_WIDTH;
    logic [TILE_W-1:0]         cfg_data      = '0;
    logic                      req_valid     = 1'b0;
    logic                      req_ready;
    logic                      action        = ACT_WRITE;
    logic [5:0]                cell_x        = '0;
    logic [5:0]                cell_y        = '0;
    logic                      cell_walkable = 1'b0;
    logic signed [COORD_W-1:0] pos_x         = '0;
    logic signed [COORD_W-1:0] pos_y         = '0;
    logic [SIZE_W-1:0]         size_x        = '0;
    logic [SIZE_W-1:0]         size_y        = '0;
    logic                      rsp_valid;
    logic                      rsp_ready     = 1'b0;
    logic                      can_occupy;

    logic [ROOM_W-1:0] room_w = 7'd64;
    logic [ROOM_W-1:0] room_h = 7'd64;
    logic [TILE_W-1:0] tile_w = 8'd8;
    logic [TILE_W-1:0] tile_h = 8'd8;
    bit                walk_map [MAX_ROOM_HEIGHT][MAX_ROOM_WIDTH];

    tile_word_t pending_words[$];
    bit         occupancy_due[$];
    tile_word_t cur_word;
    logic       req_took = 1'b0;
    logic       due_answer;

    int burst_left  = 0;
    int gap_left    = 0;
    int hold_left   = 0;
    bit hold_done   = 1'b0;
    int mode_left   = 0;
    rx_mode_t ready_mode = RX_OPEN;
    int idle_cycles = 0;

    int rsp_total  = 0;
    int n_open     = 0;
    int n_blocked  = 0;
    int n_writes   = 0;
    int n_queries  = 0;
    int n_settings = 1;
    int fail_count = 0;

    tile_rect_occupancy_check DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .req_valid     (req_valid),
        .req_ready     (req_ready),
        .action        (action),
        .cell_x        (cell_x),
        .cell_y        (cell_y),
        .cell_walkable (cell_walkable),
        .pos_x         (pos_x),
        .pos_y         (pos_y),
        .size_x        (size_x),
        .size_y        (size_y),
        .rsp_valid     (rsp_valid),
        .rsp_ready     (rsp_ready),
        .can_occupy    (can_occupy)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int floor_tiles(int num, int den);
        int q;
        q = num / den;
        if ((num % den) != 0 && num < 0)
            q = q - 1;
        return q;
    endfunction

    function automatic bit rect_fits(tile_word_t w);
        int rw;
        int rh;
        int lt;
        int tt;
        int rt;
        int bt;
        rw = (int'(room_w) > MAX_ROOM_WIDTH) ? MAX_ROOM_WIDTH : int'(room_w);
        rh = (int'(room_h) > MAX_ROOM_HEIGHT) ? MAX_ROOM_HEIGHT : int'(room_h);
        if (tile_w == 0 || tile_h == 0 || rw == 0 || rh == 0)
            return 1'b0;
        lt = floor_tiles(int'(w.px), int'(tile_w));
        tt = floor_tiles(int'(w.py), int'(tile_h));
        rt = floor_tiles(int'(w.px) + int'(w.sx) - 1, int'(tile_w));
        bt = floor_tiles(int'(w.py) + int'(w.sy) - 1, int'(tile_h));
        if (lt < 0 || tt < 0 || rt >= rw || bt >= rh)
            return 1'b0;
        for (int y = tt; y <= bt; y++)
            for (int x = lt; x <= rt; x++)
                if (!walk_map[y][x])
                    return 1'b0;
        return 1'b1;
    endfunction

    function automatic tile_word_t random_word();
        tile_word_t w;
        w.action = 1'($urandom_range(0, 1));
        w.cx     = COL_W'($urandom_range(0, 63));
        w.cy     = ROW_W'($urandom_range(0, 63));
        w.walk   = 1'($urandom_range(0, 1));
        w.px     = COORD_W'($urandom());
        w.py     = COORD_W'($urandom());
        w.sx     = SIZE_W'($urandom());
        w.sy     = SIZE_W'($urandom());
        return w;
    endfunction

    task automatic push_write(int x, int y, bit wk);
        tile_word_t w;
        w        = random_word();
        w.action = ACT_WRITE;
        w.cx     = COL_W'(x);
        w.cy     = ROW_W'(y);
        w.walk   = wk;
        pending_words.push_back(w);
    endtask

    task automatic push_query(int px, int py, int sx, int sy);
        tile_word_t w;
        w        = random_word();
        w.action = ACT_QUERY;
        w.px     = COORD_W'(px);
        w.py     = COORD_W'(py);
        w.sx     = SIZE_W'(sx);
        w.sy     = SIZE_W'(sy);
        pending_words.push_back(w);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [TILE_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            CFG_ROOM_WIDTH:  room_w = data[ROOM_W-1:0];
            CFG_ROOM_HEIGHT: room_h = data[ROOM_W-1:0];
            CFG_TILE_WIDTH:  tile_w = data;
            default:         tile_h = data;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic configure(int rw, int rh, int tw, int th);
        write_reg(CFG_ROOM_WIDTH, TILE_W'(rw));
        write_reg(CFG_ROOM_HEIGHT, TILE_W'(rh));
        write_reg(CFG_TILE_WIDTH, TILE_W'(tw));
        write_reg(CFG_TILE_HEIGHT, TILE_W'(th));
        n_settings++;
    endtask

    task automatic settle();
        while (pending_words.size() != 0 || req_valid || occupancy_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Each random phase first sweeps a corner of the room with mostly walkable
    // cells, so that queries aimed at that corner can come back true.
    task automatic push_random(int count);
        tile_word_t w;
        int fx;
        int fy;
        int tw;
        int th;
        fx = (int'(room_w) > MAX_ROOM_WIDTH) ? MAX_ROOM_WIDTH : int'(room_w);
        fy = (int'(room_h) > MAX_ROOM_HEIGHT) ? MAX_ROOM_HEIGHT : int'(room_h);
        fx = (fx > FOCUS_TILES) ? FOCUS_TILES : fx;
        fy = (fy > FOCUS_TILES) ? FOCUS_TILES : fy;
        tw = int'(tile_w);
        th = int'(tile_h);
        for (int y = 0; y < fy; y++)
            for (int x = 0; x < fx; x++)
                push_write(x, y, $urandom_range(0, 7) != 0);
        for (int i = fx * fy; i < count; i++)
        begin
            w = random_word();
            if ($urandom_range(0, 99) < 30)
            begin
                w.action = ACT_WRITE;
                if ($urandom_range(0, 3) != 0)
                begin
                    w.cx   = COL_W'($urandom_range(0, fx - 1));
                    w.cy   = ROW_W'($urandom_range(0, fy - 1));
                    w.walk = ($urandom_range(0, 5) != 0);
                end
            end
            else
            begin
                w.action = ACT_QUERY;
                if ($urandom_range(0, 9) < 7)
                begin
                    w.px = COORD_W'($urandom_range(0, fx - 1) * tw
                                    + $urandom_range(0, tw - 1));
                    w.py = COORD_W'($urandom_range(0, fy - 1) * th
                                    + $urandom_range(0, th - 1));
                    w.sx = SIZE_W'($urandom_range(0, 2 * tw));
                    w.sy = SIZE_W'($urandom_range(0, 2 * th));
                    if ($urandom_range(0, 15) == 0)
                        w.px = COORD_W'(-int'($urandom_range(1, tw)));
                    if ($urandom_range(0, 15) == 0)
                        w.py = COORD_W'(-int'($urandom_range(1, th)));
                end
            end
            pending_words.push_back(w);
        end
    endtask

    always @(negedge clk)
    begin
        if (!rst_n)
            req_valid <= 1'b0;
        else if (!req_valid || req_took)
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                req_valid <= 1'b0;
            end
            else if (pending_words.size() != 0)
            begin
                cur_word = pending_words.pop_front();
                action        <= cur_word.action;
                cell_x        <= cur_word.cx;
                cell_y        <= cur_word.cy;
                cell_walkable <= cur_word.walk;
                pos_x         <= cur_word.px;
                pos_y         <= cur_word.py;
                size_x        <= cur_word.sx;
                size_y        <= cur_word.sy;
                req_valid     <= 1'b1;
                if (burst_left > 0)
                    burst_left--;
                else
                begin
                    burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 90)
                                                             : $urandom_range(0, 12);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
                end
            end
            else
                req_valid <= 1'b0;
        end
    end

    // The long hold-off starts only with plenty of words queued, so the
    // sender keeps offering while the output side is blocked.
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left--;
            rsp_ready <= 1'b0;
        end
        else if (!hold_done && rsp_total >= 40 && pending_words.size() > 60)
        begin
            hold_done = 1'b1;
            hold_left = LONG_HOLD;
            rsp_ready <= 1'b0;
        end
        else
        begin
            if (mode_left == 0)
            begin
                ready_mode = rx_mode_t'($urandom_range(0, 2));
                mode_left  = $urandom_range(10, 80);
            end
            else
                mode_left--;
            case (ready_mode)
                RX_OPEN:   rsp_ready <= 1'b1;
                RX_CHOPPY: rsp_ready <= ($urandom_range(0, 1) == 1);
                default:   rsp_ready <= ($urandom_range(0, 4) == 0);
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_valid && rsp_ready)
            begin
                rsp_total++;
                if (can_occupy)
                    n_open++;
                else
                    n_blocked++;
                if (occupancy_due.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= REPORT_MAX)
                        $display("%0t: response word with none expected, can_occupy=%0b",
                                 $realtime, can_occupy);
                end
                else
                begin
                    due_answer = occupancy_due.pop_front();
                    if (can_occupy !== due_answer)
                    begin
                        fail_count++;
                        if (fail_count <= REPORT_MAX)
                            $display("%0t: can_occupy mismatch, expected %0b got %0b",
                                     $realtime, due_answer, can_occupy);
                    end
                end
            end
            if (req_valid && req_ready)
            begin
                if (cur_word.action == ACT_WRITE)
                begin
                    walk_map[cur_word.cy][cur_word.cx] = cur_word.walk;
                    n_writes++;
                end
                else
                begin
                    occupancy_due.push_back(rect_fits(cur_word));
                    n_queries++;
                end
            end
        end
        req_took <= rst_n && req_valid && req_ready;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no word moved for %0d cycles", $realtime, idle_cycles);
            $display("TEST FAILED");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        push_query(0, 0, 8, 8);
        push_write(0, 0, 1'b1);
        push_write(1, 0, 1'b1);
        push_write(0, 1, 1'b1);
        push_write(1, 1, 1'b1);
        push_write(63, 63, 1'b1);
        push_query(0, 0, 16, 16);
        push_query(0, 0, 17, 16);
        push_query(8, 8, 0, 0);
        push_query(0, 0, 0, 0);
        push_query(-1, 0, 2, 2);
        push_query(-32768, 32767, 4095, 4095);
        push_query(504, 504, 8, 8);
        push_query(504, 504, 9, 8);
        push_write(63, 63, 1'b0);
        push_query(504, 504, 8, 8);
        settle();

        configure(8'h81, 8'h01, 8'hFF, 8'hFF);
        push_query(0, 0, 255, 255);
        push_query(0, 0, 256, 1);
        push_write(5, 5, 1'b1);
        settle();

        configure(8'h7F, 8'h40, 8'h01, 8'h01);
        push_query(5, 5, 1, 1);
        push_query(0, 0, 2, 2);
        push_query(0, 0, 3, 2);
        settle();

        configure(0, 64, 8, 8);
        push_query(0, 0, 8, 8);
        settle();
        configure(64, 0, 8, 8);
        push_query(0, 0, 8, 8);
        settle();
        configure(64, 64, 0, 8);
        push_query(0, 0, 8, 8);
        settle();
        configure(64, 64, 8, 0);
        push_query(0, 0, 8, 8);
        settle();

        configure(6, 5, 8, 8);
        push_random(150);
        settle();
        configure(12, 4, 1, 3);
        push_random(150);
        settle();
        configure(64, 64, 16, 5);
        push_random(150);
        settle();
        configure(100, 3, 255, 200);
        push_random(150);
        settle();
        configure(2, 64, 3, 255);
        push_random(150);
        settle();

        $display("Covered %0d cell writes and %0d rectangle queries over %0d register settings.",
                 n_writes, n_queries, n_settings);
        $display("Responses: %0d rectangles fit, %0d blocked, %0d failures.",
                 n_open, n_blocked, fail_count);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

FILE: files.f
rtl/troc_pkg.sv
rtl/troc_ram.sv
rtl/troc_divider.sv
rtl/tile_rect_occupancy_check.sv
sim/tile_rect_occupancy_check_tb.sv
